/* hdl/i2cs_pkg.sv */
// I2C master bus sequencer: shared constants for commands, phases and registers.
// No dependencies.
package i2cs_pkg;

	localparam int CmdW   = 3;
	localparam int ByteW  = 8;
	localparam int PhaseW = 5;
	localparam int BitCntW = 4;
	localparam int CfgIdxW = 8;

	// command codes
	localparam logic [CmdW-1:0] CMD_NONE  = 3'd0;
	localparam logic [CmdW-1:0] CMD_START = 3'd1;
	localparam logic [CmdW-1:0] CMD_STOP  = 3'd2;
	localparam logic [CmdW-1:0] CMD_WRITE = 3'd3;
	localparam logic [CmdW-1:0] CMD_READ  = 3'd4;
	localparam logic [CmdW-1:0] CMD_WAIT_ACK = 3'd5;
	localparam logic [CmdW-1:0] CMD_ACK   = 3'd6;
	localparam logic [CmdW-1:0] CMD_NACK  = 3'd7;

	// sequencer phases
	localparam logic [PhaseW-1:0] PH_IDLE    = 5'd0;
	localparam logic [PhaseW-1:0] PH_ST_HIGH = 5'd1;
	localparam logic [PhaseW-1:0] PH_ST_SDA  = 5'd2;
	localparam logic [PhaseW-1:0] PH_ST_SCL  = 5'd3;
	localparam logic [PhaseW-1:0] PH_SP_LOW  = 5'd4;
	localparam logic [PhaseW-1:0] PH_SP_HIGH = 5'd5;
	localparam logic [PhaseW-1:0] PH_SP_END  = 5'd6;
	localparam logic [PhaseW-1:0] PH_WR_BIT  = 5'd7;
	localparam logic [PhaseW-1:0] PH_WR_HIGH = 5'd8;
	localparam logic [PhaseW-1:0] PH_WR_LOW  = 5'd9;
	localparam logic [PhaseW-1:0] PH_WR_END  = 5'd10;
	localparam logic [PhaseW-1:0] PH_RD_LOW  = 5'd11;
	localparam logic [PhaseW-1:0] PH_RD_HIGH = 5'd12;
	localparam logic [PhaseW-1:0] PH_AK_SET  = 5'd13;
	localparam logic [PhaseW-1:0] PH_AK_HIGH = 5'd14;
	localparam logic [PhaseW-1:0] PH_AK_LOW  = 5'd15;
	localparam logic [PhaseW-1:0] PH_WA_SETUP = 5'd16;
	localparam logic [PhaseW-1:0] PH_WA_HIGH = 5'd17;
	localparam logic [PhaseW-1:0] PH_WA_POLL = 5'd18;

	// configuration register indexes
	localparam logic [CfgIdxW-1:0] CFG_HALF_BIT   = 8'd0;
	localparam logic [CfgIdxW-1:0] CFG_START_STOP = 8'd1;
	localparam logic [CfgIdxW-1:0] CFG_SHORT_PHASE = 8'd2;
	localparam logic [CfgIdxW-1:0] CFG_POLL_LIMIT = 8'd3;

	localparam logic [ByteW-1:0] RST_HALF_BIT    = 8'd2;
	localparam logic [ByteW-1:0] RST_START_STOP  = 8'd4;
	localparam logic [ByteW-1:0] RST_SHORT_PHASE = 8'd1;
	localparam logic [ByteW-1:0] RST_POLL_LIMIT  = 8'd250;

	// a programmed delay of zero counts as one tick
	function automatic logic [ByteW-1:0] at_least_one(input logic [ByteW-1:0] v);
		return (v == '0) ? ByteW'(1) : v;
	endfunction

endpackage

/* hdl/i2cs_in_if.sv */
// Input tick channel: command, write byte, ack choice and sampled SDA.
// Depends on i2cs_pkg.
interface i2cs_in_if;
	import i2cs_pkg::*;
	logic             valid;
	logic             ready;
	logic [CmdW-1:0]  cmd;
	logic [ByteW-1:0] tx_byte;
	logic             send_ack;
	logic             sda_sample;

	modport source (output valid, cmd, tx_byte, send_ack, sda_sample, input ready);
	modport sink (input valid, cmd, tx_byte, send_ack, sda_sample, output ready);
endinterface

/* hdl/i2cs_out_if.sv */
// Result channel: pin levels and status for one tick.
// Depends on i2cs_pkg.
interface i2cs_out_if;
	import i2cs_pkg::*;
	logic             valid;
	logic             ready;
	logic             scl_level;
	logic             sda_level;
	logic             sda_drive;
	logic             busy_res;
	logic             done_res;
	logic [ByteW-1:0] rx_byte;
	logic             ack_failed;
	logic             cmd_dropped;

	modport source (output valid, scl_level, sda_level, sda_drive, busy_res, done_res,
		rx_byte, ack_failed, cmd_dropped, input ready);
	modport sink (input valid, scl_level, sda_level, sda_drive, busy_res, done_res,
		rx_byte, ack_failed, cmd_dropped, output ready);
endinterface

/* hdl/i2cs_cfg_if.sv */
// Configuration write channel: register index and write data.
// Depends on i2cs_pkg.
interface i2cs_cfg_if;
	import i2cs_pkg::*;
	logic               valid;
	logic               ready;
	logic [CfgIdxW-1:0] index;
	logic [ByteW-1:0]   data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* hdl/i2c_master_bus_sequencer.sv */
// I2C master bus sequencer: one tick transaction in, one result transaction out.
// The result of a tick is on the output register in the cycle after acceptance.
// Throughput: one tick per cycle while the sink is ready; the phase logic is one pass from state to result register.
// The input stalls only while a result waits in the output register and the sink is not ready.
// Reset: idle, SCL/SDA high and driven, timing registers at defaults, no result pending.
// Depends on i2cs_pkg, i2cs_in_if, i2cs_out_if, i2cs_cfg_if.
module i2c_master_bus_sequencer (
	input  logic      clk,
	input  logic      arst_n,
	i2cs_in_if.sink   in_ch,
	i2cs_out_if.source out_ch,
	i2cs_cfg_if.sink  cfg
);
	import i2cs_pkg::*;

	logic [ByteW-1:0]   half_bit_q, start_stop_q, short_phase_q, poll_limit_q;
	logic [PhaseW-1:0]  phase_q, n_phase;
	logic [ByteW-1:0]   tick_q, n_tick;
	logic [BitCntW-1:0] bit_q, n_bit;
	logic [ByteW-1:0]   shift_q, n_shift;
	logic [ByteW-1:0]   rx_q, n_rx;
	logic [ByteW-1:0]   poll_q, n_poll;
	logic               ack_send_q, n_ack_send;
	logic               fail_q, n_fail;
	logic               scl_q, n_scl;
	logic               sda_q, n_sda;
	logic               dir_q, n_dir;
	logic               n_done, n_dropped;
	logic               run;
	logic [PhaseW-1:0]  rph;
	logic               out_valid_q;
	logic               in_acc;

	assign cfg.ready    = 1'b1;
	assign in_ch.ready  = !out_valid_q || out_ch.ready;
	assign in_acc       = in_ch.valid && in_ch.ready;
	assign out_ch.valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_bit_q    <= RST_HALF_BIT;
			start_stop_q  <= RST_START_STOP;
			short_phase_q <= RST_SHORT_PHASE;
			poll_limit_q  <= RST_POLL_LIMIT;
		end else if (cfg.valid) begin
			if (cfg.index == CFG_HALF_BIT) half_bit_q <= cfg.data;
			if (cfg.index == CFG_START_STOP) start_stop_q <= cfg.data;
			if (cfg.index == CFG_SHORT_PHASE) short_phase_q <= cfg.data;
			if (cfg.index == CFG_POLL_LIMIT) poll_limit_q <= cfg.data;
		end
	end

	// next-state logic for one tick
	always_comb begin
		n_phase    = phase_q;
		n_tick     = tick_q;
		n_bit      = bit_q;
		n_shift    = shift_q;
		n_rx       = rx_q;
		n_poll     = poll_q;
		n_ack_send = ack_send_q;
		n_fail     = fail_q;
		n_scl      = scl_q;
		n_sda      = sda_q;
		n_dir      = dir_q;
		n_done     = 1'b0;
		n_dropped  = 1'b0;
		run        = 1'b0;
		rph        = phase_q;

		if (phase_q == PH_IDLE) begin
			if (in_ch.cmd != CMD_NONE) begin
				run   = 1'b1;
				n_bit = '0;
				unique case (in_ch.cmd)
					CMD_START: rph = PH_ST_HIGH;
					CMD_STOP: rph = PH_SP_LOW;
					CMD_WRITE: begin
						n_shift = in_ch.tx_byte;
						rph = PH_WR_BIT;
					end
					CMD_READ: begin
						n_shift = '0;
						n_ack_send = in_ch.send_ack;
						rph = PH_RD_LOW;
					end
					CMD_WAIT_ACK: begin
						n_fail = 1'b0;
						n_poll = '0;
						rph = PH_WA_SETUP;
					end
					CMD_ACK: begin
						n_ack_send = 1'b1;
						rph = PH_AK_SET;
					end
					default: begin
						n_ack_send = 1'b0;
						rph = PH_AK_SET;
					end
				endcase
			end
		end else begin
			n_dropped = (in_ch.cmd != CMD_NONE);
			if (phase_q == PH_WA_POLL || tick_q <= ByteW'(1)) run = 1'b1;
			else n_tick = tick_q - ByteW'(1);
		end

		if (run) begin
			unique case (rph)
				PH_ST_HIGH: begin
					n_dir = 1'b1; n_sda = 1'b1; n_scl = 1'b1;
					n_phase = PH_ST_SDA; n_tick = at_least_one(start_stop_q);
				end
				PH_ST_SDA: begin
					n_sda = 1'b0;
					n_phase = PH_ST_SCL; n_tick = at_least_one(start_stop_q);
				end
				PH_ST_SCL: begin
					n_scl = 1'b0;
					n_phase = PH_IDLE; n_tick = '0; n_done = 1'b1;
				end
				PH_SP_LOW: begin
					n_dir = 1'b1; n_scl = 1'b0; n_sda = 1'b0;
					n_phase = PH_SP_HIGH; n_tick = at_least_one(start_stop_q);
				end
				PH_SP_HIGH: begin
					n_scl = 1'b1; n_sda = 1'b1;
					n_phase = PH_SP_END; n_tick = at_least_one(start_stop_q);
				end
				PH_WR_BIT: begin
					n_dir = 1'b1; n_scl = 1'b0;
					n_sda = n_shift[ByteW-1];
					n_shift = {n_shift[ByteW-2:0], 1'b0};
					n_phase = PH_WR_HIGH; n_tick = at_least_one(half_bit_q);
				end
				PH_WR_HIGH: begin
					n_scl = 1'b1;
					n_phase = PH_WR_LOW; n_tick = at_least_one(half_bit_q);
				end
				PH_WR_LOW: begin
					n_scl = 1'b0;
					n_bit = n_bit + BitCntW'(1);
					n_phase = (n_bit >= BitCntW'(8)) ? PH_WR_END : PH_WR_BIT;
					n_tick = at_least_one(half_bit_q);
				end
				PH_RD_LOW: begin
					n_dir = 1'b0; n_scl = 1'b0;
					n_phase = PH_RD_HIGH; n_tick = at_least_one(half_bit_q);
				end
				PH_RD_HIGH: begin
					n_scl = 1'b1;
					n_shift = {n_shift[ByteW-2:0], in_ch.sda_sample};
					n_bit = n_bit + BitCntW'(1);
					n_tick = at_least_one(short_phase_q);
					if (n_bit >= BitCntW'(8)) begin
						n_rx = n_shift;
						n_phase = PH_AK_SET;
					end else begin
						n_phase = PH_RD_LOW;
					end
				end
				PH_AK_SET: begin
					n_scl = 1'b0; n_dir = 1'b1;
					n_sda = !n_ack_send;
					n_phase = PH_AK_HIGH; n_tick = at_least_one(half_bit_q);
				end
				PH_AK_HIGH: begin
					n_scl = 1'b1;
					n_phase = PH_AK_LOW; n_tick = at_least_one(half_bit_q);
				end
				PH_AK_LOW: begin
					n_scl = 1'b0;
					n_phase = PH_IDLE; n_tick = '0; n_done = 1'b1;
				end
				PH_WA_SETUP: begin
					n_dir = 1'b0; n_sda = 1'b1;
					n_phase = PH_WA_HIGH; n_tick = at_least_one(short_phase_q);
				end
				PH_WA_HIGH: begin
					n_scl = 1'b1;
					n_poll = '0;
					n_phase = PH_WA_POLL; n_tick = at_least_one(short_phase_q);
				end
				PH_WA_POLL: begin
					if (!in_ch.sda_sample) begin
						n_scl = 1'b0;
						n_phase = PH_IDLE; n_tick = '0; n_done = 1'b1;
					end else if (poll_q >= poll_limit_q) begin
						// timeout: flag it and begin the stop sequence on this tick
						n_fail = 1'b1;
						n_dir = 1'b1; n_scl = 1'b0; n_sda = 1'b0;
						n_phase = PH_SP_HIGH; n_tick = at_least_one(start_stop_q);
					end else begin
						n_poll = poll_q + ByteW'(1);
					end
				end
				default: begin
					n_phase = PH_IDLE; n_tick = '0; n_done = 1'b1;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			tick_q     <= '0;
			bit_q      <= '0;
			shift_q    <= '0;
			rx_q       <= '0;
			poll_q     <= '0;
			ack_send_q <= 1'b0;
			fail_q     <= 1'b0;
			scl_q      <= 1'b1;
			sda_q      <= 1'b1;
			dir_q      <= 1'b1;
		end else if (in_acc) begin
			phase_q    <= n_phase;
			tick_q     <= n_tick;
			bit_q      <= n_bit;
			shift_q    <= n_shift;
			rx_q       <= n_rx;
			poll_q     <= n_poll;
			ack_send_q <= n_ack_send;
			fail_q     <= n_fail;
			scl_q      <= n_scl;
			sda_q      <= n_sda;
			dir_q      <= n_dir;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_acc) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result register, payload only
	always_ff @(posedge clk) begin
		if (in_acc) begin
			out_ch.scl_level   <= n_scl;
			out_ch.sda_level   <= n_sda;
			out_ch.sda_drive   <= n_dir;
			out_ch.busy_res    <= (n_phase != PH_IDLE);
			out_ch.done_res    <= n_done;
			out_ch.rx_byte     <= n_rx;
			out_ch.ack_failed  <= n_fail;
			out_ch.cmd_dropped <= n_dropped;
		end
	end

`ifndef ASSERT_OFF
	a_tick_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != PH_IDLE) |-> (tick_q != '0))
		else $error("waiting phase with zero tick count");

	a_bit_range: assert property (@(posedge clk) disable iff (!arst_n)
		bit_q <= BitCntW'(8))
		else $error("bit count beyond one byte");

	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> !(out_ch.done_res && out_ch.busy_res))
		else $error("result reports done while still busy");

	a_cmd_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && phase_q == PH_IDLE && in_ch.cmd != CMD_NONE) |=> (phase_q != PH_IDLE))
		else $error("accepted command did not leave idle");

	a_fail_from_poll: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(fail_q) |-> ($past(phase_q) == PH_WA_POLL))
		else $error("ack failure raised outside ack polling");
`endif

endmodule

/* sim/i2cs_bus_checker.sv */
// Scoreboard for the I2C master bus sequencer: mirrors the tick-by-tick pin sequencing,
// predicts every result transaction and compares it field by field with the block.
// Depends on i2cs_pkg, i2cs_in_if, i2cs_out_if and i2cs_cfg_if.
module i2cs_bus_checker (
	input  logic clk,
	input  logic arst_n,
	i2cs_in_if   in_ch,
	i2cs_out_if  out_ch,
	i2cs_cfg_if  cfg,
	output int   fail_count,
	output int   outstanding,
	output logic seq_busy
);
	import i2cs_pkg::*;

	typedef struct packed {
		logic             scl;
		logic             sda;
		logic             drive;
		logic             busy;
		logic             done;
		logic [ByteW-1:0] rx;
		logic             fail;
		logic             dropped;
	} pins_t;

	pins_t pending_pins[$];

	// timing registers
	logic [ByteW-1:0] half_ticks, hold_ticks, short_ticks, poll_limit;

	// sequencer state
	logic [PhaseW-1:0]  ph;
	logic [ByteW-1:0]   wait_left, shifter, rx_latch, polls;
	logic [BitCntW-1:0] bit_idx;
	logic               ack_drive, ack_fail, scl, sda_o, sda_dir;

	function automatic void hold(input logic [PhaseW-1:0] nxt, input logic [ByteW-1:0] n);
		ph = nxt;
		wait_left = (n == '0) ? ByteW'(1) : n;
	endfunction

	function automatic void stop_begin();
		sda_dir = 1'b1;
		scl = 1'b0;
		sda_o = 1'b0;
		hold(PH_SP_HIGH, hold_ticks);
	endfunction

	// pin actions of the current phase; returns 1 when the command completes
	function automatic logic advance(input logic s);
		logic fin;
		fin = 1'b0;
		case (ph)
			PH_ST_HIGH: begin
				sda_dir = 1'b1;
				sda_o = 1'b1;
				scl = 1'b1;
				hold(PH_ST_SDA, hold_ticks);
			end
			PH_ST_SDA: begin
				sda_o = 1'b0;
				hold(PH_ST_SCL, hold_ticks);
			end
			PH_ST_SCL: begin
				scl = 1'b0;
				fin = 1'b1;
			end
			PH_SP_LOW: stop_begin();
			PH_SP_HIGH: begin
				scl = 1'b1;
				sda_o = 1'b1;
				hold(PH_SP_END, hold_ticks);
			end
			PH_WR_BIT: begin
				sda_dir = 1'b1;
				scl = 1'b0;
				sda_o = shifter[ByteW-1];
				shifter = shifter << 1;
				hold(PH_WR_HIGH, half_ticks);
			end
			PH_WR_HIGH: begin
				scl = 1'b1;
				hold(PH_WR_LOW, half_ticks);
			end
			PH_WR_LOW: begin
				scl = 1'b0;
				bit_idx = bit_idx + 1'b1;
				hold((bit_idx >= 4'd8) ? PH_WR_END : PH_WR_BIT, half_ticks);
			end
			PH_RD_LOW: begin
				sda_dir = 1'b0;
				scl = 1'b0;
				hold(PH_RD_HIGH, half_ticks);
			end
			PH_RD_HIGH: begin
				scl = 1'b1;
				shifter = {shifter[ByteW-2:0], s};
				bit_idx = bit_idx + 1'b1;
				if (bit_idx >= 4'd8) begin
					rx_latch = shifter;
					hold(PH_AK_SET, short_ticks);
				end else begin
					hold(PH_RD_LOW, short_ticks);
				end
			end
			PH_AK_SET: begin
				scl = 1'b0;
				sda_dir = 1'b1;
				sda_o = ~ack_drive;
				hold(PH_AK_HIGH, half_ticks);
			end
			PH_AK_HIGH: begin
				scl = 1'b1;
				hold(PH_AK_LOW, half_ticks);
			end
			PH_AK_LOW: begin
				scl = 1'b0;
				fin = 1'b1;
			end
			PH_WA_SETUP: begin
				sda_dir = 1'b0;
				sda_o = 1'b1;
				hold(PH_WA_HIGH, short_ticks);
			end
			PH_WA_HIGH: begin
				scl = 1'b1;
				polls = '0;
				hold(PH_WA_POLL, short_ticks);
			end
			PH_WA_POLL: begin
				if (!s) begin
					scl = 1'b0;
					fin = 1'b1;
				end else if (polls >= poll_limit) begin
					// timeout: flag it and begin a stop on this same tick
					ack_fail = 1'b1;
					stop_begin();
				end else begin
					polls = polls + 1'b1;
				end
			end
			default: fin = 1'b1;
		endcase
		if (fin) begin
			ph = PH_IDLE;
			wait_left = '0;
		end
		return fin;
	endfunction

	function automatic pins_t take_tick(input logic [CmdW-1:0] c, input logic [ByteW-1:0] b,
			input logic a, input logic s);
		pins_t r;
		logic fin, drop;
		fin = 1'b0;
		drop = 1'b0;
		if (ph == PH_IDLE) begin
			if (c != CMD_NONE) begin
				bit_idx = '0;
				case (c)
					CMD_START: ph = PH_ST_HIGH;
					CMD_STOP: ph = PH_SP_LOW;
					CMD_WRITE: begin
						shifter = b;
						ph = PH_WR_BIT;
					end
					CMD_READ: begin
						shifter = '0;
						ack_drive = a;
						ph = PH_RD_LOW;
					end
					CMD_WAIT_ACK: begin
						ack_fail = 1'b0;
						polls = '0;
						ph = PH_WA_SETUP;
					end
					CMD_ACK: begin
						ack_drive = 1'b1;
						ph = PH_AK_SET;
					end
					default: begin
						ack_drive = 1'b0;
						ph = PH_AK_SET;
					end
				endcase
				fin = advance(s);
			end
		end else begin
			drop = (c != CMD_NONE);
			if (ph == PH_WA_POLL || wait_left <= 8'd1) fin = advance(s);
			else wait_left = wait_left - 1'b1;
		end
		r.scl = scl;
		r.sda = sda_o;
		r.drive = sda_dir;
		r.busy = (ph != PH_IDLE);
		r.done = fin;
		r.rx = rx_latch;
		r.fail = ack_fail;
		r.dropped = drop;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [ByteW-1:0] want_v,
			input logic [ByteW-1:0] got_v);
		if (got_v !== want_v) begin
			$error("%s: expected %0h, got %0h", name, want_v, got_v);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		pins_t want;
		if (!arst_n) begin
			half_ticks = RST_HALF_BIT;
			hold_ticks = RST_START_STOP;
			short_ticks = RST_SHORT_PHASE;
			poll_limit = RST_POLL_LIMIT;
			ph = PH_IDLE;
			wait_left = '0;
			bit_idx = '0;
			shifter = '0;
			rx_latch = '0;
			polls = '0;
			ack_drive = 1'b0;
			ack_fail = 1'b0;
			scl = 1'b1;
			sda_o = 1'b1;
			sda_dir = 1'b1;
			pending_pins.delete();
			fail_count = 0;
			outstanding = 0;
			seq_busy = 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				if (pending_pins.size() == 0) begin
					$error("result transaction with no tick pending");
					fail_count++;
				end else begin
					want = pending_pins.pop_front();
					check_field("scl_level", want.scl, out_ch.scl_level);
					check_field("sda_level", want.sda, out_ch.sda_level);
					check_field("sda_drive", want.drive, out_ch.sda_drive);
					check_field("busy_res", want.busy, out_ch.busy_res);
					check_field("done_res", want.done, out_ch.done_res);
					check_field("rx_byte", want.rx, out_ch.rx_byte);
					check_field("ack_failed", want.fail, out_ch.ack_failed);
					check_field("cmd_dropped", want.dropped, out_ch.cmd_dropped);
				end
			end
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					CFG_HALF_BIT: half_ticks = cfg.data;
					CFG_START_STOP: hold_ticks = cfg.data;
					CFG_SHORT_PHASE: short_ticks = cfg.data;
					CFG_POLL_LIMIT: poll_limit = cfg.data;
					default: ;
				endcase
			end
			if (in_ch.valid && in_ch.ready)
				pending_pins.push_back(take_tick(in_ch.cmd, in_ch.tx_byte, in_ch.send_ack,
					in_ch.sda_sample));
			outstanding = pending_pins.size();
			seq_busy = (ph != PH_IDLE);
		end
	end

endmodule

/* sim/tb_i2c_master_bus_sequencer.sv */
// Testbench top for the I2C master bus sequencer: drives tick and configuration
// transactions with random idling and backpressure, and reports the verdict.
// Depends on i2cs_pkg, the channel interfaces, i2c_master_bus_sequencer, i2cs_bus_checker.
module tb_i2c_master_bus_sequencer;
	import i2cs_pkg::*;

	localparam int CYCLE_LIMIT = 500000;
	localparam int LONG_HOLD = 200;
	localparam int PHASE_TICKS = 30;
	localparam int SDA_RANDOM = -1;
	localparam int ACK_NEVER = 1000000;
	localparam logic [CfgIdxW-1:0] CFG_NO_REG = 8'hFF;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   outstanding;
	logic seq_busy;
	bit   tx_quiet, rx_quiet, rx_hold;
	int   cur_short, cur_limit;
	int   ticks_sent;

	i2cs_in_if  in_ch();
	i2cs_out_if out_ch();
	i2cs_cfg_if cfg();

	i2c_master_bus_sequencer uut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cfg    (cfg)
	);

	i2cs_bus_checker scoreboard (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_ch       (in_ch),
		.out_ch      (out_ch),
		.cfg         (cfg),
		.fail_count  (fail_count),
		.outstanding (outstanding),
		.seq_busy    (seq_busy)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("status: fail");
		$finish;
	end

	// result sink: random stalls, one long hold-off on request
	initial begin
		int gap;
		out_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			gap = rx_quiet ? 0 : $urandom_range(0, 8);
			if (rx_hold) begin
				gap = LONG_HOLD;
				rx_hold = 1'b0;
			end
			if (gap > 0) begin
				out_ch.ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			out_ch.ready <= 1'b1;
			do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
		end
	end

	// entered and left at a falling edge; valid stays high for a back-to-back tick
	task automatic send_tick(input logic [CmdW-1:0] c, input logic [ByteW-1:0] b,
			input logic a, input logic s);
		int gap;
		gap = tx_quiet ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_ch.cmd <= c;
		in_ch.tx_byte <= b;
		in_ch.send_ack <= a;
		in_ch.sda_sample <= s;
		in_ch.valid <= 1'b1;
		do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
		ticks_sent++;
		@(negedge clk);
	endtask

	task automatic idle_input();
		in_ch.valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [ByteW-1:0] val);
		cfg.index <= idx;
		cfg.data <= val;
		cfg.valid <= 1'b1;
		do @(posedge clk); while (!(cfg.valid && cfg.ready));
		@(negedge clk);
		cfg.valid <= 1'b0;
		@(negedge clk);
	endtask

	// let the running command finish, then wait for every result
	task automatic drain();
		while (seq_busy)
			send_tick(CMD_NONE, ByteW'($urandom), 1'($urandom), 1'($urandom));
		idle_input();
		while (outstanding != 0) @(negedge clk);
	endtask

	task automatic set_timing(input logic [ByteW-1:0] h, input logic [ByteW-1:0] s,
			input logic [ByteW-1:0] q, input logic [ByteW-1:0] l);
		drain();
		write_reg(CFG_HALF_BIT, h);
		write_reg(CFG_START_STOP, s);
		write_reg(CFG_SHORT_PHASE, q);
		write_reg(CFG_POLL_LIMIT, l);
		cur_short = q;
		cur_limit = l;
	endtask

	// SDA seen by the block: random for SDA_RANDOM, else high for the first 'highs' ticks of a command, then low
	function automatic logic bus_sda(input int k, input int highs);
		return (highs == SDA_RANDOM) ? 1'($urandom) : (k < highs);
	endfunction

	function automatic int ack_wait_highs();
		if (cur_limit <= 8 && $urandom_range(0, 3) == 0) return ACK_NEVER;
		return $urandom_range(0, 2 * cur_short + 6);
	endfunction

	// issue one command and feed ticks until it completes; stray commands get dropped
	task automatic run_cmd(input logic [CmdW-1:0] c, input logic [ByteW-1:0] b,
			input logic a, input int highs);
		int k;
		logic [CmdW-1:0] stray;
		k = 0;
		send_tick(c, b, a, bus_sda(k, highs));
		while (seq_busy) begin
			k++;
			stray = ($urandom_range(0, 15) == 0) ?
				CmdW'($urandom_range(CMD_START, CMD_NACK)) : CMD_NONE;
			send_tick(stray, ByteW'($urandom), 1'($urandom), bus_sda(k, highs));
		end
	endtask

	task automatic random_transfer();
		int n;
		if ($urandom_range(0, 4) == 0) begin
			run_cmd(CmdW'($urandom_range(CMD_NONE, CMD_NACK)), ByteW'($urandom),
				1'($urandom), SDA_RANDOM);
		end else begin
			run_cmd(CMD_START, ByteW'($urandom), 1'($urandom), SDA_RANDOM);
			run_cmd(CMD_WRITE, ByteW'($urandom), 1'($urandom), SDA_RANDOM);
			run_cmd(CMD_WAIT_ACK, ByteW'($urandom), 1'($urandom), ack_wait_highs());
			n = $urandom_range(0, 3);
			repeat (n) begin
				case ($urandom_range(0, 3))
					0: begin
						run_cmd(CMD_WRITE, ByteW'($urandom), 1'($urandom), SDA_RANDOM);
						run_cmd(CMD_WAIT_ACK, ByteW'($urandom), 1'($urandom),
							ack_wait_highs());
					end
					1: run_cmd(CMD_READ, ByteW'($urandom), 1'($urandom), SDA_RANDOM);
					2: run_cmd(CMD_ACK, ByteW'($urandom), 1'($urandom), SDA_RANDOM);
					default: run_cmd(CMD_NACK, ByteW'($urandom), 1'($urandom), SDA_RANDOM);
				endcase
			end
			// sometimes no stop, so the next start is a repeated start
			if ($urandom_range(0, 5) != 0)
				run_cmd(CMD_STOP, ByteW'($urandom), 1'($urandom), SDA_RANDOM);
		end
	endtask

	initial begin
		int  phase_start;
		bit  paused;
		in_ch.valid = 1'b0;
		in_ch.cmd = CMD_NONE;
		in_ch.tx_byte = '0;
		in_ch.send_ack = 1'b0;
		in_ch.sda_sample = 1'b1;
		cfg.valid = 1'b0;
		cfg.index = CFG_HALF_BIT;
		cfg.data = '0;
		tx_quiet = 1'b0;
		rx_quiet = 1'b0;
		rx_hold = 1'b0;
		cur_short = RST_SHORT_PHASE;
		cur_limit = RST_POLL_LIMIT;
		ticks_sent = 0;
		paused = 1'b0;
		arst_n = 1'b0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// short transfer at reset timing
		run_cmd(CMD_START, '0, 1'b0, SDA_RANDOM);
		run_cmd(CMD_WRITE, ByteW'($urandom), 1'b0, SDA_RANDOM);
		run_cmd(CMD_WAIT_ACK, '0, 1'b0, 3);
		run_cmd(CMD_STOP, '0, 1'b0, SDA_RANDOM);

		// fastest timing, every command, byte extremes
		set_timing(8'd1, 8'd1, 8'd1, 8'd1);
		write_reg(CFG_NO_REG, 8'h00);
		run_cmd(CMD_START, '0, 1'b0, SDA_RANDOM);
		run_cmd(CMD_WRITE, 8'hFF, 1'b1, SDA_RANDOM);
		run_cmd(CMD_WAIT_ACK, '0, 1'b0, 0);
		run_cmd(CMD_WRITE, 8'h00, 1'b0, SDA_RANDOM);
		run_cmd(CMD_WAIT_ACK, '0, 1'b0, 3);
		run_cmd(CMD_READ, '0, 1'b1, 0);
		run_cmd(CMD_READ, '0, 1'b0, ACK_NEVER);
		run_cmd(CMD_ACK, '0, 1'b0, SDA_RANDOM);
		run_cmd(CMD_NACK, '0, 1'b1, SDA_RANDOM);
		run_cmd(CMD_NONE, '0, 1'b0, SDA_RANDOM);
		run_cmd(CMD_WAIT_ACK, '0, 1'b0, ACK_NEVER);
		run_cmd(CMD_STOP, '0, 1'b0, SDA_RANDOM);

		// zero everywhere: delays act as one tick, first high poll fails
		set_timing(8'd0, 8'd0, 8'd0, 8'd0);
		run_cmd(CMD_WAIT_ACK, '0, 1'b0, ACK_NEVER);
		run_cmd(CMD_START, '0, 1'b0, SDA_RANDOM);
		run_cmd(CMD_READ, '0, 1'b1, SDA_RANDOM);

		// slowest timing: one start, about 500 ticks on its own
		set_timing(8'd255, 8'd255, 8'd255, 8'd255);
		run_cmd(CMD_START, '0, 1'b0, SDA_RANDOM);

		for (int p = 0; p < 5; p++) begin
			case (p)
				0: set_timing(8'd1, 8'd1, 8'd1, 8'd3);
				1: set_timing(RST_HALF_BIT, RST_START_STOP, RST_SHORT_PHASE, RST_POLL_LIMIT);
				2: set_timing(8'd3, 8'd2, 8'd2, 8'd6);
				3: set_timing(ByteW'($urandom_range(1, 3)), ByteW'($urandom_range(1, 3)),
					ByteW'($urandom_range(0, 2)), ByteW'($urandom_range(0, 8)));
				default: set_timing(ByteW'($urandom_range(1, 4)), ByteW'($urandom_range(1, 4)),
					ByteW'($urandom_range(1, 3)), ByteW'($urandom_range(0, 8)));
			endcase
			tx_quiet = (p == 3);
			rx_quiet = (p == 3);
			// sink holds off while ticks keep coming, so the input backs up
			rx_hold = (p == 1);
			phase_start = ticks_sent;
			while (ticks_sent - phase_start < PHASE_TICKS) begin
				random_transfer();
				if (p == 2 && !paused) begin
					idle_input();
					while (outstanding != 0) @(negedge clk);
					paused = 1'b1;
				end
			end
		end

		idle_input();
		while (outstanding != 0) @(negedge clk);
		repeat (8) @(negedge clk);
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

/* sim.f */
hdl/i2cs_pkg.sv
hdl/i2cs_in_if.sv
hdl/i2cs_out_if.sv
hdl/i2cs_cfg_if.sv
hdl/i2c_master_bus_sequencer.sv
sim/i2cs_bus_checker.sv
sim/tb_i2c_master_bus_sequencer.sv
